[sv/sine_cosine_of_pi_phase_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sine/cosine of pi phase block
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_OF_PI_PHASE_DEFINES_SVH
`define SINE_COSINE_OF_PI_PHASE_DEFINES_SVH

// Check a property only while out of reset.
`define SCP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SCP_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/scp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg
// Types, constants and the Q2.30 multiply shared by the sine/cosine pipeline.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned FRAC      = 30;
  localparam int unsigned STEPS     = 6;  // cosine series terms
  localparam int unsigned SIN_STEPS = 5;  // sine series terms

  localparam logic [30:0] ONE_Q        = 31'h4000_0000;
  localparam logic [29:0] HALF_Q       = 30'h2000_0000;
  localparam logic [29:0] QUARTER_PI_Q = 30'd843314857;
  localparam logic [63:0] ONE_W        = 64'h4000_0000;

  localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  // floor(2^30 / k): quotient estimate is exact or one low
  localparam logic [29:0] SIN_RCP [SIN_STEPS] = '{
    30'(ONE_W / 64'd110), 30'(ONE_W / 64'd72), 30'(ONE_W / 64'd42),
    30'(ONE_W / 64'd20), 30'(ONE_W / 64'd6)};
  localparam logic [29:0] COS_RCP [STEPS] = '{
    30'(ONE_W / 64'd132), 30'(ONE_W / 64'd90), 30'(ONE_W / 64'd56),
    30'(ONE_W / 64'd30), 30'(ONE_W / 64'd12), 30'(ONE_W / 64'd2)};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic [29:0] theta;
    logic [29:0] t2;
    logic [30:0] acc_s;
    logic [30:0] acc_c;
    quad_e       quad;
    logic        flip;
  } lane_t;

  // floor(a * b / 2^30); a < 2^30 and b <= 2^30 keep the product below 2^60
  function automatic logic [29:0] mulq(input logic [29:0] a, input logic [30:0] b);
    logic [60:0] p;
    p = 61'(a) * 61'(b);
    return p[59:30];
  endfunction

endpackage

[sv/scp_reduce.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_reduce
// Phase fold into [0, pi/4], scale to radians and square; three stages.
// ----------------------------------------------------------------------------
module scp_reduce #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output logic                  stall_o,
  output logic                  valid_o,
  output scp_pkg::lane_t        data_o,
  input  logic                  stall_i
);
  import scp_pkg::*;

  localparam int unsigned ZW = PHASE_BITS - 2;
  localparam logic [ZW-1:0] QUARTER = ZW'(1) << (PHASE_BITS - 3);

  typedef struct packed {
    logic [30:0] u;
    quad_e       quad;
    logic        flip;
  } fold_t;

  typedef struct packed {
    logic [29:0] theta;
    quad_e       quad;
    logic        flip;
  } ang_t;

  logic    v1_q, v2_q, v3_q;
  logic    rdy1, rdy2, rdy3;
  fold_t   st1_d, st1_q;
  ang_t    st2_d, st2_q;
  lane_t   st3_d, st3_q;
  logic [ZW-1:0] r, z;
  logic [30:0]   u;
  logic [60:0]   th_prod;

  assign rdy3    = !v3_q || !stall_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign stall_o = !rdy1;

  // fold the remainder above a quarter back toward zero
  assign r = phase_i[ZW-1:0];
  assign z = (r > QUARTER) ? (ZW'(0) - r) : r;

  if (PHASE_BITS <= 33) begin : g_up
    assign u = 31'(z) << (33 - PHASE_BITS);
  end else begin : g_dn
    assign u = 31'(z >> (PHASE_BITS - 33));
  end

  always_comb begin
    st1_d.u    = u;
    st1_d.quad = quad_e'(phase_i[PHASE_BITS-1:PHASE_BITS-2]);
    st1_d.flip = r > QUARTER;
  end

  // theta = round(u * pi/4)
  assign th_prod = 61'(st1_q.u) * 61'(QUARTER_PI_Q) + 61'(HALF_Q);

  always_comb begin
    st2_d.theta = th_prod[59:30];
    st2_d.quad  = st1_q.quad;
    st2_d.flip  = st1_q.flip;
  end

  always_comb begin
    st3_d.theta = st2_q.theta;
    st3_d.t2    = mulq(st2_q.theta, {1'b0, st2_q.theta});
    st3_d.acc_s = ONE_Q;
    st3_d.acc_c = ONE_Q;
    st3_d.quad  = st2_q.quad;
    st3_d.flip  = st2_q.flip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) st1_q <= st1_d;
    if (rdy2 && v1_q)    st2_q <= st2_d;
    if (rdy3 && v2_q)    st3_q <= st3_d;
  end

  assign valid_o = v3_q;
  assign data_o  = st3_q;

endmodule

[sv/scp_series.sv]
`timescale 1ns / 1ps
`include "sine_cosine_of_pi_phase_defines.svh"
// ----------------------------------------------------------------------------
// scp_series
// Horner evaluation of the sine and cosine series, three stages per term.
// ----------------------------------------------------------------------------
module scp_series (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  scp_pkg::lane_t data_i,
  output logic           stall_o,
  output logic           valid_o,
  output scp_pkg::lane_t data_o,
  input  logic           stall_i
);
  import scp_pkg::*;

  typedef struct packed {
    lane_t       lane;
    logic [29:0] m_s;
    logic [29:0] m_c;
  } prod_t;

  typedef struct packed {
    lane_t       lane;
    logic [29:0] m_s;
    logic [29:0] m_c;
    logic [29:0] q_s;
    logic [29:0] q_c;
  } quot_t;

  logic  v1_q [STEPS];
  logic  v2_q [STEPS];
  logic  v3_q [STEPS];
  logic  rdy1 [STEPS];
  logic  rdy2 [STEPS];
  logic  rdy3 [STEPS];
  logic  src_v [STEPS];
  logic  dst_rdy [STEPS];
  lane_t src [STEPS];
  prod_t st1_q [STEPS];
  quot_t st2_q [STEPS];
  lane_t st3_q [STEPS];

  genvar i;
  for (i = 0; i < STEPS; i++) begin : g_step
    prod_t       st1_d;
    quot_t       st2_d;
    lane_t       st3_d;
    logic [59:0] pc;
    logic [29:0] q_s_est;
    logic [29:0] rem_c, fix_c;
    logic [30:0] acc_s_nxt;

    if (i == 0) begin : g_head
      assign src_v[i] = valid_i;
      assign src[i]   = data_i;
    end else begin : g_link
      assign src_v[i] = v3_q[i-1];
      assign src[i]   = st3_q[i-1];
    end

    if (i == STEPS - 1) begin : g_tail
      assign dst_rdy[i] = !stall_i;
    end else begin : g_mid
      assign dst_rdy[i] = rdy1[i+1];
    end

    assign rdy3[i] = !v3_q[i] || dst_rdy[i];
    assign rdy2[i] = !v2_q[i] || rdy3[i];
    assign rdy1[i] = !v1_q[i] || rdy2[i];

    // m = t2 * acc
    always_comb begin
      st1_d.lane = src[i];
      st1_d.m_s  = mulq(src[i].t2, src[i].acc_s);
      st1_d.m_c  = mulq(src[i].t2, src[i].acc_c);
    end

    // quotient estimate by reciprocal, one low at most
    assign pc = 60'(st1_q[i].m_c) * 60'(COS_RCP[i]);

    if (i < SIN_STEPS) begin : g_sin
      logic [59:0] ps;
      logic [29:0] rem_s, fix_s;
      assign ps      = 60'(st1_q[i].m_s) * 60'(SIN_RCP[i]);
      assign q_s_est = ps[59:30];
      assign rem_s   = st2_q[i].m_s - 30'(38'(st2_q[i].q_s) * 38'(SIN_DIV[i]));
      assign fix_s   = st2_q[i].q_s + 30'(rem_s >= 30'(SIN_DIV[i]));
      assign acc_s_nxt = ONE_Q - {1'b0, fix_s};
    end else begin : g_sin_hold
      // sine series is one term shorter: hold its accumulator
      assign q_s_est   = '0;
      assign acc_s_nxt = st2_q[i].lane.acc_s;
    end

    always_comb begin
      st2_d.lane = st1_q[i].lane;
      st2_d.m_s  = st1_q[i].m_s;
      st2_d.m_c  = st1_q[i].m_c;
      st2_d.q_s  = q_s_est;
      st2_d.q_c  = pc[59:30];
    end

    // correct the estimate and close the Horner term
    assign rem_c = st2_q[i].m_c - 30'(38'(st2_q[i].q_c) * 38'(COS_DIV[i]));
    assign fix_c = st2_q[i].q_c + 30'(rem_c >= 30'(COS_DIV[i]));

    always_comb begin
      st3_d       = st2_q[i].lane;
      st3_d.acc_s = acc_s_nxt;
      st3_d.acc_c = ONE_Q - {1'b0, fix_c};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q[i] <= 1'b0;
        v2_q[i] <= 1'b0;
        v3_q[i] <= 1'b0;
      end else begin
        if (rdy1[i]) v1_q[i] <= src_v[i];
        if (rdy2[i]) v2_q[i] <= v1_q[i];
        if (rdy3[i]) v3_q[i] <= v2_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy1[i] && src_v[i]) st1_q[i] <= st1_d;
      if (rdy2[i] && v1_q[i])  st2_q[i] <= st2_d;
      if (rdy3[i] && v2_q[i])  st3_q[i] <= st3_d;
    end
  end

  assign stall_o = !rdy1[0];
  assign valid_o = v3_q[STEPS-1];
  assign data_o  = st3_q[STEPS-1];

  `SCP_ASSERT(a_ser_empty_head_ready, !v1_q[0] |-> !stall_o, "series stalls with empty head stage")

endmodule

[sv/scp_finish.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_finish
// Final sine multiply, output rounding, saturation and quadrant mapping.
// ----------------------------------------------------------------------------
module scp_finish #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  scp_pkg::lane_t             data_i,
  output logic                       stall_o,
  output logic                       valid_o,
  output logic signed [OUT_BITS-1:0] sine_o,
  output logic signed [OUT_BITS-1:0] cosine_o,
  input  logic                       stall_i
);
  import scp_pkg::*;

  localparam int unsigned SW = OUT_BITS + FRAC;
  localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};

  typedef struct packed {
    logic [29:0] sin_q;
    logic [30:0] cos_q;
    quad_e       quad;
    logic        flip;
  } fin_t;

  logic                       v1_q, vout_q;
  logic                       rdy1, rdy2;
  fin_t                       st1_d, st1_q;
  logic [SW-1:0]              sin_sc, cos_sc;
  logic [OUT_BITS-1:0]        ss_raw, cc_raw, ss, cc, sw_s, sw_c, neg_s, neg_c;
  logic signed [OUT_BITS-1:0] sine_d, cosine_d, sine_q, cosine_q;

  assign rdy2    = !vout_q || !stall_i;
  assign rdy1    = !v1_q || rdy2;
  assign stall_o = !rdy1;

  always_comb begin
    st1_d.sin_q = mulq(data_i.theta, data_i.acc_s);
    st1_d.cos_q = data_i.acc_c;
    st1_d.quad  = data_i.quad;
    st1_d.flip  = data_i.flip;
  end

  // round half up to OUT_BITS, then clip at full scale
  assign sin_sc = (SW'(st1_q.sin_q) << (OUT_BITS - 1)) + SW'(HALF_Q);
  assign cos_sc = (SW'(st1_q.cos_q) << (OUT_BITS - 1)) + SW'(HALF_Q);
  assign ss_raw = sin_sc[SW-1:FRAC];
  assign cc_raw = cos_sc[SW-1:FRAC];
  assign ss     = (ss_raw > OUT_MAX) ? OUT_MAX : ss_raw;
  assign cc     = (cc_raw > OUT_MAX) ? OUT_MAX : cc_raw;

  // swap back angles folded past a quarter
  assign sw_s  = st1_q.flip ? cc : ss;
  assign sw_c  = st1_q.flip ? ss : cc;
  assign neg_s = -sw_s;
  assign neg_c = -sw_c;

  always_comb begin
    case (st1_q.quad)
      QUAD_0: begin
        sine_d   = sw_s;
        cosine_d = sw_c;
      end
      QUAD_1: begin
        sine_d   = sw_c;
        cosine_d = neg_s;
      end
      QUAD_2: begin
        sine_d   = neg_s;
        cosine_d = neg_c;
      end
      QUAD_3: begin
        sine_d   = neg_c;
        cosine_d = sw_s;
      end
      default: begin
        sine_d   = '0;
        cosine_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (rdy1) v1_q   <= valid_i;
      if (rdy2) vout_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) st1_q <= st1_d;
    if (rdy2 && v1_q) begin
      sine_q   <= sine_d;
      cosine_q <= cosine_d;
    end
  end

  assign valid_o  = vout_q;
  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

endmodule

[sv/sine_cosine_of_pi_phase.sv]
`timescale 1ns / 1ps
`include "sine_cosine_of_pi_phase_defines.svh"
// Throughput: one beat per cycle while no stall holds the pipeline;
// every stage is a registered step with its own valid bit.
// Depth is 3 reduction stages, 3 stages for each of the 6 series terms, 2 output stages.
// A stall holds only the stages that are full; empty stages keep filling behind it.
// Reset (rst_ni low, asynchronous) clears all valid bits; no beat is in flight afterward.
// ----------------------------------------------------------------------------
// sine_cosine_of_pi_phase
// sin(pi*x) and cos(pi*x) of an unsigned full-cycle phase, saturated Q1.15.
// ----------------------------------------------------------------------------
module sine_cosine_of_pi_phase #(
  parameter int unsigned PHASE_BITS = 32,
  parameter int unsigned OUT_BITS   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [PHASE_BITS-1:0]      phase_i,
  output logic                       stall_o,
  output logic                       valid_o,
  output logic signed [OUT_BITS-1:0] sine_o,
  output logic signed [OUT_BITS-1:0] cosine_o,
  input  logic                       stall_i
);
  import scp_pkg::*;

  localparam logic [OUT_BITS-1:0] MIN_CODE   = OUT_BITS'(1) << (OUT_BITS - 1);
  localparam logic [OUT_BITS-1:0] HALF_SCALE = OUT_BITS'(1) << (OUT_BITS - 2);

  logic  red_v, red_stall, ser_v, ser_stall;
  lane_t red_lane, ser_lane;
  logic [OUT_BITS-1:0] sine_mag, cosine_mag;

  // Fold the phase to the first octant and form theta and theta^2.
  scp_reduce #(
    .PHASE_BITS(PHASE_BITS)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .phase_i (phase_i),
    .stall_o (stall_o),
    .valid_o (red_v),
    .data_o  (red_lane),
    .stall_i (red_stall)
  );

  // Advance both Horner series one term per three stages.
  scp_series u_series (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (red_v),
    .data_i  (red_lane),
    .stall_o (red_stall),
    .valid_o (ser_v),
    .data_o  (ser_lane),
    .stall_i (ser_stall)
  );

  // Finish sine with theta, round, clip, then map by quadrant into the output register.
  scp_finish #(
    .OUT_BITS(OUT_BITS)
  ) u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ser_v),
    .data_i   (ser_lane),
    .stall_o  (ser_stall),
    .valid_o  (valid_o),
    .sine_o   (sine_o),
    .cosine_o (cosine_o),
    .stall_i  (stall_i)
  );

  // Magnitudes for the unit-circle sanity check.
  assign sine_mag   = sine_o[OUT_BITS-1]   ? -sine_o   : sine_o;
  assign cosine_mag = cosine_o[OUT_BITS-1] ? -cosine_o : cosine_o;

  `SCP_ASSERT(a_no_min_code, valid_o |-> (sine_o != MIN_CODE) && (cosine_o != MIN_CODE), "result hits negative full scale")
  `SCP_ASSERT(a_on_circle, valid_o |-> (sine_mag >= HALF_SCALE) || (cosine_mag >= HALF_SCALE), "result pair is off the unit circle")
  `SCP_ASSERT_RST(a_reset_empty, !rst_ni |-> !valid_o, "result beat shown during reset")

endmodule

[verif/sine_cosine_of_pi_phase_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_of_pi_phase_checker
// Watches the phase and result channels, computes the expected sine/cosine
// pair of each accepted phase beat and compares it with the result beats in order.
// ----------------------------------------------------------------------------
module sine_cosine_of_pi_phase_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [31:0]        in_phase_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] sine_i,
  input  logic signed [15:0] cosine_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o,
  output int unsigned        results_o
);
  import scp_pkg::*;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned Q30_HALF    = 64'd1 << 29;
  localparam longint unsigned QUARTER_REM = 64'd1 << 29;  // 0.25 in phase LSBs
  localparam longint unsigned PI_4_Q30    = 64'd843314857;
  localparam longint unsigned Q15_MAX     = 64'd32767;
  localparam int unsigned     SHOWN_MAX   = 10;

  typedef struct packed {
    logic [31:0]        phase;
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
  } sincos_beat_t;

  sincos_beat_t expected_pairs[$];
  int unsigned  error_count;
  int unsigned  result_count;
  int unsigned  pending_count;

  assign errors_o  = error_count;
  assign pending_o = pending_count;
  assign results_o = result_count;

  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b) >> 30;
  endfunction

  // Round half up into Q1.15 and clip at the top; a full 1.0 lands on 32767.
  function automatic logic signed [15:0] to_q15(input longint unsigned q);
    longint unsigned v;
    v = ((q << 15) + Q30_HALF) >> 30;
    if (v > Q15_MAX) v = Q15_MAX;
    return 16'(v);
  endfunction

  function automatic sincos_beat_t predict_sincos(input logic [31:0] phase);
    quad_e           quad;
    longint unsigned z;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned acc;
    longint unsigned sin_q;
    longint unsigned divisor;
    logic            folded;
    logic signed [15:0] s;
    logic signed [15:0] c;
    logic signed [15:0] tmp;
    sincos_beat_t    r;
    quad   = quad_e'(phase[31:30]);
    z      = 64'(phase[29:0]);
    folded = 1'b0;
    // fold the upper half of the quadrant back onto [0, 0.25]; exactly 0.25 stays
    if (z > QUARTER_REM) begin
      z      = 2 * QUARTER_REM - z;
      folded = 1'b1;
    end
    theta = ((z << 1) * PI_4_Q30 + Q30_HALF) >> 30;
    t2    = q30_mul(theta, theta);
    // nested Horner form: sine divisors are 2m(2m+1), m = 5..1
    acc = Q30_ONE;
    for (int m = 5; m >= 1; m--) begin
      divisor = 64'((2 * m) * (2 * m + 1));
      acc     = Q30_ONE - q30_mul(t2, acc) / divisor;
    end
    sin_q = q30_mul(theta, acc);
    // cosine divisors are (2m-1)2m, m = 6..1
    acc = Q30_ONE;
    for (int m = 6; m >= 1; m--) begin
      divisor = 64'((2 * m - 1) * (2 * m));
      acc     = Q30_ONE - q30_mul(t2, acc) / divisor;
    end
    s = to_q15(sin_q);
    c = to_q15(acc);
    if (folded) begin
      tmp = s;
      s   = c;
      c   = tmp;
    end
    r.phase = phase;
    case (quad)
      QUAD_0: begin
        r.sine   = s;
        r.cosine = c;
      end
      QUAD_1: begin
        r.sine   = c;
        r.cosine = -s;
      end
      QUAD_2: begin
        r.sine   = -s;
        r.cosine = -c;
      end
      default: begin
        r.sine   = -c;
        r.cosine = s;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sincos_beat_t want;
    if (!rst_ni) begin
      expected_pairs.delete();
      error_count   = 0;
      result_count  = 0;
      pending_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_pairs.push_back(predict_sincos(in_phase_i));
      if (out_valid_i && !out_stall_i) begin
        result_count++;
        if (expected_pairs.size() == 0) begin
          error_count++;
          if (error_count <= SHOWN_MAX)
            $display("[%0t] unexpected result beat: sine %0d cosine %0d",
                     $realtime, sine_i, cosine_i);
        end else begin
          want = expected_pairs.pop_front();
          if (sine_i !== want.sine || cosine_i !== want.cosine) begin
            error_count++;
            if (error_count <= SHOWN_MAX)
              $display("[%0t] phase %h: sine %0d (want %0d) cosine %0d (want %0d)",
                       $realtime, want.phase, sine_i, want.sine, cosine_i, want.cosine);
          end
        end
      end
      pending_count = expected_pairs.size();
    end
  end

endmodule

[verif/sine_cosine_of_pi_phase_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_of_pi_phase_test
// Drives phase beats into the sine/cosine block, directed corners first and then
// random phases under four idle/stall mixes; the checker scores every result.
// ----------------------------------------------------------------------------
module sine_cosine_of_pi_phase_test;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_PER_MIX = 413;
  localparam int unsigned MIX_COUNT     = 4;
  localparam int unsigned TAIL_CYCLES   = 60;      // pipeline is 23 deep
  localparam int unsigned CORNER_COUNT  = 22;

  logic               clk_i;
  logic               rst_ni;
  logic               valid_i;
  logic [31:0]        phase_i;
  logic               stall_o;
  logic               valid_o;
  logic signed [15:0] sine_o;
  logic signed [15:0] cosine_o;
  logic               stall_i;

  int unsigned errors;
  int unsigned pending;
  int unsigned results;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned beats_sent;

  // Quadrant starts (cosine of zero clips to 32767, negated zeros), the exact
  // one-quarter remainder that must not fold, its neighbors, and the wrap point.
  logic [31:0] corner_phases [CORNER_COUNT] = '{
    32'h0000_0000, 32'h0000_0001, 32'h1FFF_FFFF, 32'h2000_0000, 32'h2000_0001,
    32'h3FFF_FFFF, 32'h4000_0000, 32'h4000_0001, 32'h6000_0000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'hA000_0000, 32'hBFFF_FFFF, 32'hC000_0000,
    32'hC000_0001, 32'hE000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
    32'h3FFF_FFFE, 32'h1234_5678};

  sine_cosine_of_pi_phase dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_i),
    .phase_i  (phase_i),
    .stall_o  (stall_o),
    .valid_o  (valid_o),
    .sine_o   (sine_o),
    .cosine_o (cosine_o),
    .stall_i  (stall_i)
  );

  sine_cosine_of_pi_phase_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (valid_i),
    .in_stall_i  (stall_o),
    .in_phase_i  (phase_i),
    .out_valid_i (valid_o),
    .out_stall_i (stall_i),
    .sine_i      (sine_o),
    .cosine_i    (cosine_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop: no legal run comes anywhere near this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: redraw stall every falling edge at the current rate.
  always @(negedge clk_i) begin
    stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Present one phase beat and hold it until the block takes it. Leave at the
  // falling edge after acceptance so the next beat can follow back to back.
  task automatic send_phase(input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(negedge clk_i);
    end
    valid_i <= 1'b1;
    phase_i <= value;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain_results();
    valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  // Mostly uniform phases; the rest crowd the quadrant edges, the fold point
  // and tiny angles, where rounding and clipping are most delicate.
  function automatic logic [31:0] random_phase();
    logic [1:0]  quad;
    logic [31:0] jitter;
    quad   = 2'($urandom_range(3));
    jitter = 32'($urandom_range(16)) - 32'd8;
    case ($urandom_range(9))
      6:       return {quad, 30'h0} + jitter;
      7:       return {quad, 30'h2000_0000} + jitter;
      8:       return {quad, 30'($urandom_range(1023))};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_ni         = 1'b0;
    valid_i        = 1'b0;
    phase_i        = '0;
    stall_i        = 1'b0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    beats_sent     = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners at full rate
    for (int i = 0; i < CORNER_COUNT; i++) send_phase(corner_phases[i]);
    drain_results();

    // random phases under each idle/stall mix, draining fully between mixes
    for (int mix = 0; mix < MIX_COUNT; mix++) begin
      case (mix)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 52;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 52;
        end
        default: begin
          send_idle_pct  = 22;
          recv_stall_pct = 22;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_MIX; n++) send_phase(random_phase());
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d phase beats (%0d corners, rest random over %0d idle/stall mixes);",
             beats_sent, CORNER_COUNT, MIX_COUNT);
    $display("compared %0d result beats, %0d mismatches.", results, errors);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
